// ===== hdl/gbm_pkg.sv =====
package gbm_pkg;

  // Longest pattern that the store holds.
  localparam int MAX_PATTERN = 64;

  // Pattern positions run from 0 to MAX_PATTERN inclusive.
  localparam int POS_N = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Stream field widths.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int OUT_W  = 8;

  // Command codes carried on the input side.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

  // Wildcard bytes.
  localparam logic [BYTE_W-1:0] ANY_ONE = 8'h3F;
  localparam logic [BYTE_W-1:0] ANY_RUN = 8'h2A;

  typedef logic [POS_N-1:0] pos_vec_t;

endpackage

// ===== hdl/wildcard_glob_matcher.sv =====
// Wildcard glob matcher. A pattern is loaded one byte at a time (command
// "append", after a "clear"), where '?' matches any one byte and '*' any run of
// bytes, including an empty one. Text bytes then stream in, and the "end of
// text" command yields one result transfer that says whether the whole text
// matched and whether pattern bytes were dropped because the store was full.
// No command holds the input: the set of live pattern positions is updated
// in a single pass, with a carry chain spreading positions across runs of
// stars, so one item is accepted in every cycle. Intake stops only while a
// result sits in the output register and the downstream side is not ready.
// After an end of text the same pattern is ready for the next text.
module wildcard_glob_matcher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [gbm_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_value
  input  logic [gbm_pkg::CMD_W-1:0]  s_tuser,   // [1:0] command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [gbm_pkg::OUT_W-1:0]  m_tdata    // [0] matched, [1] pattern_overflow
);

  import gbm_pkg::*;

  logic [BYTE_W-1:0] pattern_store [MAX_PATTERN];
  logic [LEN_W-1:0]  pattern_length;
  logic [LEN_W-1:0]  pattern_length_next;
  pos_vec_t          active;
  pos_vec_t          active_next;
  logic              overflow_flag;
  logic              overflow_flag_next;
  logic              matched;
  logic              pattern_overflow;

  logic              accept;
  logic              store_write;
  pos_vec_t          star_mask;
  pos_vec_t          hit_mask;
  pos_vec_t          gen_bits;
  logic [POS_N:0]    chain_sum;
  logic [POS_N:0]    chain_carry;
  pos_vec_t          closed;
  pos_vec_t          advanced;

  // The input is taken whenever the result register is free or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Per-position classification of the stored pattern against the text byte.
  always_comb begin
    star_mask = '0;
    hit_mask  = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < pattern_length) begin
        star_mask[j] = (pattern_store[j] == ANY_RUN);
        hit_mask[j]  = (pattern_store[j] != ANY_RUN) &&
                       ((pattern_store[j] == ANY_ONE) || (pattern_store[j] == s_tdata));
      end
    end
  end

  // Star closure as a carry chain: a live star generates a carry into the
  // next position, and any star passes an incoming carry along.
  assign gen_bits    = active & star_mask;
  assign chain_sum   = {1'b0, star_mask} + {1'b0, gen_bits};
  assign chain_carry = chain_sum ^ {1'b0, star_mask} ^ {1'b0, gen_bits};
  assign closed      = active | chain_carry[POS_N-1:0];

  // A star keeps its position live, a matching byte moves one position on.
  assign advanced = (closed & star_mask) | ((closed & hit_mask) << 1);

  // Next state for the command being accepted.
  always_comb begin
    pattern_length_next = pattern_length;
    overflow_flag_next  = overflow_flag;
    active_next         = active;
    store_write         = 1'b0;
    if (accept) begin
      case (s_tuser)
        CMD_CLEAR: begin
          pattern_length_next = '0;
          overflow_flag_next  = 1'b0;
          active_next         = POS_N'(1);
        end
        CMD_APPEND: begin
          if (pattern_length < LEN_W'(MAX_PATTERN)) begin
            store_write         = 1'b1;
            pattern_length_next = pattern_length + LEN_W'(1);
          end else begin
            overflow_flag_next = 1'b1;
          end
          active_next = POS_N'(1);
        end
        CMD_TEXT: begin
          active_next = advanced;
        end
        CMD_END: begin
          active_next = POS_N'(1);
        end
        default: begin
          active_next = active;
        end
      endcase
    end
  end

  // Result of an end of text.
  assign matched          = closed[pattern_length] && !overflow_flag;
  assign pattern_overflow = overflow_flag;

  // Pattern store: written at the current length, no reset needed.
  always_ff @(posedge clk) begin
    if (store_write) begin
      pattern_store[pattern_length[IDX_W-1:0]] <= s_tdata;
    end
  end

  // Matcher state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      overflow_flag  <= 1'b0;
      active         <= POS_N'(1);
    end else begin
      pattern_length <= pattern_length_next;
      overflow_flag  <= overflow_flag_next;
      active         <= active_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && (s_tuser == CMD_END)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (s_tuser == CMD_END)) begin
      m_tdata <= {(OUT_W-2)'(0), pattern_overflow, matched};
    end
  end

endmodule

// ===== hdl/gbm_checker.sv =====
module gbm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [gbm_pkg::BYTE_W-1:0] s_tdata,
  input logic [gbm_pkg::CMD_W-1:0]  s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [gbm_pkg::OUT_W-1:0]  m_tdata
);

  import gbm_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // An overflowed pattern never reports a match.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("match reported with overflowed pattern");

  // Every end-of-text transfer produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_END) |=> m_tvalid)
    else $error("end of text gave no result");

  // A new result only follows an end-of-text transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_END)))
    else $error("result without end of text");

  // Padding bits of the result stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_W-1:2] == '0))
    else $error("result padding not zero");

endmodule

bind wildcard_glob_matcher gbm_checker u_gbm_checker (.*);

// ===== sim/glob_match_checker.sv =====
module glob_match_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [gbm_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_value
  input  logic [gbm_pkg::CMD_W-1:0]  s_tuser,   // [1:0] command
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [gbm_pkg::OUT_W-1:0]  m_tdata,   // [0] matched, [1] pattern_overflow
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbm_pkg::*;

  localparam pos_vec_t START_POS = pos_vec_t'(1);

  typedef struct packed {
    logic hit;
    logic ovf;
  } verdict_t;

  // Shadow copy of the pattern and of the live position set.
  logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
  int unsigned       pat_len;
  pos_vec_t          live;
  logic              ovf_seen;
  verdict_t          verdict_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // A star may match an empty run, so the position after a live star is live too.
  // Walking upward lets a run of stars carry the position along.
  function automatic pos_vec_t spread_stars(input pos_vec_t v);
    pos_vec_t r;
    r = v;
    for (int j = 0; j < pat_len; j++)
      if (r[j] && pat_mem[j] == ANY_RUN) r[j+1] = 1'b1;
    return r;
  endfunction

  // One text byte moves every live position forward, or keeps it on a star.
  function automatic pos_vec_t advance_text(input pos_vec_t v, input logic [BYTE_W-1:0] c);
    pos_vec_t cur;
    pos_vec_t nxt;
    cur = spread_stars(v);
    nxt = '0;
    for (int j = 0; j < pat_len; j++) begin
      if (cur[j]) begin
        if (pat_mem[j] == ANY_RUN) nxt[j] = 1'b1;
        else if (pat_mem[j] == ANY_ONE || pat_mem[j] == c) nxt[j+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  // Results are checked before inputs are applied; the output is registered,
  // so a result never belongs to a command accepted at the same edge.
  always @(posedge clk) begin
    verdict_t want;
    pos_vec_t closed;
    if (rst) begin
      pat_len  = 0;
      ovf_seen = 1'b0;
      live     = START_POS;
      verdict_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected, got %h", $time, m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.hit) begin
            errors++;
            $display("%0t: matched mismatch: expected %0b, got %0b",
                     $time, want.hit, m_tdata[0]);
          end
          if (m_tdata[1] !== want.ovf) begin
            errors++;
            $display("%0t: pattern_overflow mismatch: expected %0b, got %0b",
                     $time, want.ovf, m_tdata[1]);
          end
          if (m_tdata[OUT_W-1:2] !== '0) begin
            errors++;
            $display("%0t: padding mismatch: expected 0, got %h", $time, m_tdata[OUT_W-1:2]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          CMD_CLEAR: begin
            pat_len  = 0;
            ovf_seen = 1'b0;
            live     = START_POS;
          end
          CMD_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
              pat_mem[pat_len] = s_tdata;
              pat_len++;
            end else begin
              ovf_seen = 1'b1;
            end
            live = START_POS;
          end
          CMD_TEXT: live = advance_text(live, s_tdata);
          CMD_END: begin
            closed   = spread_stars(live);
            want.hit = closed[pat_len] && !ovf_seen;
            want.ovf = ovf_seen;
            verdict_q.push_back(want);
            live = START_POS;
          end
          default: ;
        endcase
      end
    end
    pending <= verdict_q.size();
  end

endmodule

// ===== sim/wildcard_glob_matcher_tb.sv =====
module wildcard_glob_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbm_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 1650;
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata  = '0;
  logic [CMD_W-1:0]  s_tuser  = CMD_CLEAR;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  int   errors;
  int   pending;
  int   send_idle  = 0;
  int   recv_stall = 0;
  logic hold_req   = 1'b0;
  int   items_sent = 0;
  int   quiet      = 0;

  // Pattern as loaded so far, used to build texts that can match.
  logic [BYTE_W-1:0] pat_q[$];

  wildcard_glob_matcher uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  glob_match_checker chk (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [BYTE_W-1:0] text_char();
    if ($urandom_range(9) == 0) return BYTE_W'($urandom_range(255));
    return CH_A + BYTE_W'($urandom_range(2));
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 20) return ANY_RUN;
    if (r < 35) return ANY_ONE;
    if (r < 95) return CH_A + BYTE_W'($urandom_range(2));
    return BYTE_W'($urandom_range(255));
  endfunction

  // One input transfer, with random idle cycles ahead of it.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_CLEAR) pat_q.delete();
    else if (cmd == CMD_APPEND) pat_q.push_back(b);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_pattern(input int n);
    send(CMD_CLEAR, BYTE_W'($urandom_range(255)));
    repeat (n) send(CMD_APPEND, pattern_char());
  endtask

  // Text built to match the pattern, a near miss of it, or random.
  task automatic send_text(input int kind);
    logic [BYTE_W-1:0] txt[$];
    int k;
    foreach (pat_q[i]) begin
      if (i >= MAX_PATTERN) break;
      if (pat_q[i] == ANY_RUN) repeat ($urandom_range(3)) txt.push_back(text_char());
      else if (pat_q[i] == ANY_ONE) txt.push_back(BYTE_W'($urandom_range(255)));
      else txt.push_back(pat_q[i]);
    end
    if (kind == 1 && txt.size() > 0) begin
      k = $urandom_range(txt.size() - 1);
      case ($urandom_range(2))
        0: txt[k] = text_char();
        1: txt.delete(k);
        default: txt.insert(k, text_char());
      endcase
    end else if (kind == 2) begin
      txt.delete();
      repeat ($urandom_range(10)) txt.push_back(text_char());
    end
    foreach (txt[i]) send(CMD_TEXT, txt[i]);
    send(CMD_END, BYTE_W'($urandom_range(255)));
  endtask

  function automatic int pattern_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(6);
    if (r < 95) return $urandom_range(20, 7);
    return $urandom_range(MAX_PATTERN + 6, MAX_PATTERN - 9);
  endfunction

  initial begin
    int stop_at;
    int base;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty pattern: only an empty text matches.
    send(CMD_END, 8'h00);
    send(CMD_TEXT, 8'hFF);
    send(CMD_END, 8'hFF);
    // A lone star matches empty and non-empty text.
    send(CMD_CLEAR, 8'hFF);
    send(CMD_APPEND, ANY_RUN);
    send(CMD_END, 8'h00);
    send(CMD_TEXT, 8'h00);
    send(CMD_TEXT, 8'hFF);
    send(CMD_END, 8'h00);
    // Literal, any-one, star and a high byte together.
    send(CMD_CLEAR, 8'h00);
    send(CMD_APPEND, CH_A);
    send(CMD_APPEND, ANY_ONE);
    send(CMD_APPEND, ANY_RUN);
    send(CMD_APPEND, 8'hFF);
    send(CMD_TEXT, CH_A);
    send(CMD_TEXT, 8'h00);
    send(CMD_TEXT, 8'hFF);
    send(CMD_END, 8'h55);
    // Once no position is live the text cannot match.
    send(CMD_TEXT, CH_A + 8'd1);
    send(CMD_TEXT, CH_A);
    send(CMD_END, 8'hAA);
    // An append in the middle of a text restarts it.
    send(CMD_TEXT, CH_A);
    send(CMD_APPEND, CH_A + 8'd2);
    send(CMD_TEXT, CH_A);
    send(CMD_END, 8'h00);
    drain();

    // Random part in four idling phases.
    base = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      stop_at = base + (phase + 1) * ITEM_TARGET / 4;
      if (phase == 0) begin
        // Overflowing pattern, then a long receiver hold-off that backs up the input.
        load_pattern(MAX_PATTERN + 2);
        send_text(0);
        send_text(2);
        hold_req = 1'b1;
        load_pattern(3);
        repeat (8) send_text(2);
        drain();
      end
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 85) begin
          load_pattern(pattern_len());
          repeat ($urandom_range(4, 1)) send_text($urandom_range(2));
        end else begin
          repeat ($urandom_range(8, 1))
            send(CMD_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
